// File: rtl/core/pps_pkg.sv
package pps_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int IDX_W         = 6;
    localparam int SLOT_W        = 4;
    localparam int ID_W          = 8;
    localparam int ARR_W         = 16;
    localparam int BURST_W       = 16;
    localparam int PRIO_W        = 8;
    localparam int TIME_W        = 21;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN1,
        ST_SCAN2,
        ST_EXEC,
        ST_EMIT
    } t_state;

    // scan packet walking down the cell chain
    typedef struct packed {
        logic               vld;
        logic               found;
        logic [IDX_W-1:0]   idx;
        logic [PRIO_W-1:0]  prio;
        logic [ARR_W-1:0]   arr;
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] rem;
        logic               started;
        logic               have_next;
        logic [ARR_W-1:0]   next;
        logic               have_latest;
        logic [ARR_W-1:0]   latest;
    } t_scan;

    // slot write and execute controls, broadcast to all cells
    typedef struct packed {
        logic               ld;
        logic [IDX_W-1:0]   ld_slot;
        logic [ID_W-1:0]    id;
        logic [ARR_W-1:0]   arr;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic               upd;
        logic [IDX_W-1:0]   upd_slot;
    } t_cell_ctl;

endpackage

// File: rtl/core/pps_cell.sv
module pps_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pps_pkg::t_cell_ctl          i_ctl,
    input  logic [pps_pkg::TIME_W-1:0]  i_now,
    input  pps_pkg::t_scan              i_pkt,
    output pps_pkg::t_scan              o_pkt
);

    localparam logic [pps_pkg::IDX_W-1:0] MY_IDX = pps_pkg::IDX_W'(CELL_IDX);

    logic                         r_valid;
    logic                         r_started;
    logic                         r_done;
    logic [pps_pkg::ID_W-1:0]     r_id;
    logic [pps_pkg::ARR_W-1:0]    r_arr;
    logic [pps_pkg::BURST_W-1:0]  r_burst;
    logic [pps_pkg::PRIO_W-1:0]   r_prio;
    logic [pps_pkg::BURST_W-1:0]  r_rem;
    pps_pkg::t_scan               r_pkt;
    pps_pkg::t_scan               n_pkt;

    logic w_ld;
    logic w_upd;
    logic w_live;
    logic w_ready;
    logic w_better;
    logic w_later;
    logic [pps_pkg::TIME_W-1:0] w_arr_t;

    assign w_ld    = i_ctl.ld && (i_ctl.ld_slot == MY_IDX);
    assign w_upd   = i_ctl.upd && (i_ctl.upd_slot == MY_IDX);
    assign w_arr_t = pps_pkg::TIME_W'(r_arr);
    assign w_live  = r_valid && !r_done;
    assign w_ready = w_live && (r_rem != '0) && (w_arr_t <= i_now);
    assign w_later = w_live && (w_arr_t > i_now);
    assign w_better = !i_pkt.found || (r_prio < i_pkt.prio) ||
                      ((r_prio == i_pkt.prio) && (r_arr < i_pkt.arr));

    always_comb begin
        n_pkt = i_pkt;
        if (w_ready && w_better) begin
            n_pkt.found   = 1'b1;
            n_pkt.idx     = MY_IDX;
            n_pkt.prio    = r_prio;
            n_pkt.arr     = r_arr;
            n_pkt.id      = r_id;
            n_pkt.burst   = r_burst;
            n_pkt.rem     = r_rem;
            n_pkt.started = r_started;
        end
        if (w_later && (!i_pkt.have_latest || (r_arr > i_pkt.latest))) begin
            n_pkt.have_latest = 1'b1;
            n_pkt.latest      = r_arr;
        end
        if (w_later && (r_rem != '0) && (!i_pkt.have_next || (r_arr < i_pkt.next))) begin
            n_pkt.have_next = 1'b1;
            n_pkt.next      = r_arr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_started <= 1'b0;
            r_done    <= 1'b0;
        end else if (w_ld) begin
            r_valid   <= 1'b1;
            r_started <= 1'b0;
            r_done    <= 1'b0;
        end else if (w_upd) begin
            r_started <= 1'b1;
            if (r_rem == pps_pkg::BURST_W'(1)) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_id    <= i_ctl.id;
            r_arr   <= i_ctl.arr;
            r_burst <= i_ctl.burst;
            r_prio  <= i_ctl.prio;
            r_rem   <= i_ctl.burst;
        end else if (w_upd) begin
            r_rem <= r_rem - pps_pkg::BURST_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt.vld <= 1'b0;
        end else begin
            r_pkt <= n_pkt;
        end
    end

    assign o_pkt = r_pkt;

endmodule

// File: rtl/core/preemptive_priority_scheduler_top.sv
// Channel  | Handshake            | Ports
// ---------+----------------------+-----------------------------------------------
// item in  | start & !busy        | i_cmd i_slot i_task_id i_arrival_time
//          |                      | i_burst_time i_priority_req
// result   | o_strobe, one cycle  | o_ran o_run_slot o_run_task_id o_slice_start
//          |                      | o_end_time o_first_run o_response_time
//          |                      | o_finished o_turnaround_time o_waiting_time
//          |                      | o_all_done
// A load beat is written in the cycle it is taken and busy stays low; it gives no result.
// A run beat sends a scan packet down the cell chain, one cell a cycle; a found slot goes
// through EXEC and EMIT before the strobe; if no slot is ready, time jumps to the next
// arrival and the scan runs once more, else the strobe reports all done. Busy drops as the strobe rises.
// Reset (synchronous, active low) clears slot flags, time and control; no clearing pass.
// The receiver cannot stall: the result is on the ports in the strobe cycle and stays until the next run updates it.
module preemptive_priority_scheduler_top #(
    parameter int NUM_SLOTS = pps_pkg::NUM_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cmd,
    input  logic [pps_pkg::SLOT_W-1:0]    i_slot,
    input  logic [pps_pkg::ID_W-1:0]      i_task_id,
    input  logic [pps_pkg::ARR_W-1:0]     i_arrival_time,
    input  logic [pps_pkg::BURST_W-1:0]   i_burst_time,
    input  logic [pps_pkg::PRIO_W-1:0]    i_priority_req,
    output logic                          o_strobe,
    output logic                          o_ran,
    output logic [pps_pkg::SLOT_W-1:0]    o_run_slot,
    output logic [pps_pkg::ID_W-1:0]      o_run_task_id,
    output logic [pps_pkg::TIME_W-1:0]    o_slice_start,
    output logic [pps_pkg::TIME_W-1:0]    o_end_time,
    output logic                          o_first_run,
    output logic [pps_pkg::TIME_W-1:0]    o_response_time,
    output logic                          o_finished,
    output logic [pps_pkg::TIME_W-1:0]    o_turnaround_time,
    output logic [pps_pkg::TIME_W-1:0]    o_waiting_time,
    output logic                          o_all_done
);

    pps_pkg::t_state              r_state, n_state;
    logic [pps_pkg::TIME_W-1:0]   r_now, n_now;
    logic                         r_kick, n_kick;
    pps_pkg::t_scan               r_best, n_best;

    logic                         r_strobe, n_strobe;
    logic                         r_ran, n_ran;
    logic [pps_pkg::SLOT_W-1:0]   r_run_slot, n_run_slot;
    logic [pps_pkg::ID_W-1:0]     r_run_id, n_run_id;
    logic [pps_pkg::TIME_W-1:0]   r_start, n_start;
    logic [pps_pkg::TIME_W-1:0]   r_end, n_end;
    logic                         r_first, n_first;
    logic [pps_pkg::TIME_W-1:0]   r_resp, n_resp;
    logic                         r_fin, n_fin;
    logic [pps_pkg::TIME_W-1:0]   r_tat, n_tat;
    logic [pps_pkg::TIME_W-1:0]   r_wait, n_wait;
    logic                         r_all_done, n_all_done;

    logic                         w_accept;
    logic                         w_inject;
    logic [pps_pkg::TIME_W-1:0]   w_next_now;
    logic [pps_pkg::TIME_W-1:0]   w_tat;
    logic [pps_pkg::TIME_W-1:0]   w_burst_t;
    pps_pkg::t_cell_ctl           w_ctl;
    pps_pkg::t_scan               w_pkt [0:NUM_SLOTS];
    pps_pkg::t_scan               w_tail;

    assign busy     = (r_state != pps_pkg::ST_IDLE);
    assign w_accept = start && !busy;
    assign w_inject = (w_accept && (i_cmd == pps_pkg::CMD_RUN)) || r_kick;

    assign w_ctl.ld       = w_accept && (i_cmd == pps_pkg::CMD_LOAD);
    assign w_ctl.ld_slot  = pps_pkg::IDX_W'(i_slot);
    assign w_ctl.id       = i_task_id;
    assign w_ctl.arr      = i_arrival_time;
    assign w_ctl.burst    = i_burst_time;
    assign w_ctl.prio     = i_priority_req;
    assign w_ctl.upd      = (r_state == pps_pkg::ST_EXEC);
    assign w_ctl.upd_slot = r_best.idx;

    always_comb begin
        w_pkt[0]     = '0;
        w_pkt[0].vld = w_inject;
    end

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        pps_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_now   (r_now),
            .i_pkt   (w_pkt[g]),
            .o_pkt   (w_pkt[g+1])
        );
    end

    assign w_tail     = w_pkt[NUM_SLOTS];
    assign w_next_now = (r_now < pps_pkg::TIME_MAX) ? r_now + pps_pkg::TIME_W'(1) : r_now;
    assign w_tat      = w_next_now - pps_pkg::TIME_W'(r_best.arr);
    assign w_burst_t  = pps_pkg::TIME_W'(r_best.burst);

    always_comb begin
        n_state    = r_state;
        n_now      = r_now;
        n_kick     = 1'b0;
        n_best     = r_best;
        n_strobe   = 1'b0;
        n_ran      = r_ran;
        n_run_slot = r_run_slot;
        n_run_id   = r_run_id;
        n_start    = r_start;
        n_end      = r_end;
        n_first    = r_first;
        n_resp     = r_resp;
        n_fin      = r_fin;
        n_tat      = r_tat;
        n_wait     = r_wait;
        n_all_done = r_all_done;
        case (r_state)
            pps_pkg::ST_IDLE: begin
                if (w_accept && (i_cmd == pps_pkg::CMD_RUN)) begin
                    n_state = pps_pkg::ST_SCAN1;
                end
            end
            pps_pkg::ST_SCAN1, pps_pkg::ST_SCAN2: begin
                if (w_tail.vld) begin
                    if (w_tail.found) begin
                        n_best  = w_tail;
                        n_state = pps_pkg::ST_EXEC;
                    end else if (w_tail.have_next && (r_state == pps_pkg::ST_SCAN1)) begin
                        n_now   = pps_pkg::TIME_W'(w_tail.next);
                        n_kick  = 1'b1;
                        n_state = pps_pkg::ST_SCAN2;
                    end else begin
                        if (w_tail.have_latest && (r_state == pps_pkg::ST_SCAN1)) begin
                            n_now = pps_pkg::TIME_W'(w_tail.latest);
                        end
                        n_strobe   = 1'b1;
                        n_ran      = 1'b0;
                        n_run_slot = '0;
                        n_run_id   = '0;
                        n_start    = '0;
                        n_end      = '0;
                        n_first    = 1'b0;
                        n_resp     = '0;
                        n_fin      = 1'b0;
                        n_tat      = '0;
                        n_wait     = '0;
                        n_all_done = 1'b1;
                        n_state    = pps_pkg::ST_IDLE;
                    end
                end
            end
            pps_pkg::ST_EXEC: begin
                n_now      = w_next_now;
                n_ran      = 1'b1;
                n_run_slot = r_best.idx[pps_pkg::SLOT_W-1:0];
                n_run_id   = r_best.id;
                n_start    = r_now;
                n_end      = w_next_now;
                n_first    = !r_best.started;
                n_resp     = r_best.started ? '0 : r_now - pps_pkg::TIME_W'(r_best.arr);
                n_fin      = (r_best.rem == pps_pkg::BURST_W'(1));
                n_tat      = w_tat;
                n_all_done = 1'b0;
                n_state    = pps_pkg::ST_EMIT;
            end
            pps_pkg::ST_EMIT: begin
                n_strobe = 1'b1;
                if (r_fin) begin
                    n_wait = (r_tat >= w_burst_t) ? r_tat - w_burst_t : '0;
                end else begin
                    n_tat  = '0;
                    n_wait = '0;
                end
                n_state = pps_pkg::ST_IDLE;
            end
            default: begin
                n_state = pps_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pps_pkg::ST_IDLE;
            r_now    <= '0;
            r_kick   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_now    <= n_now;
            r_kick   <= n_kick;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best     <= n_best;
        r_ran      <= n_ran;
        r_run_slot <= n_run_slot;
        r_run_id   <= n_run_id;
        r_start    <= n_start;
        r_end      <= n_end;
        r_first    <= n_first;
        r_resp     <= n_resp;
        r_fin      <= n_fin;
        r_tat      <= n_tat;
        r_wait     <= n_wait;
        r_all_done <= n_all_done;
    end

    assign o_strobe          = r_strobe;
    assign o_ran             = r_ran;
    assign o_run_slot        = r_run_slot;
    assign o_run_task_id     = r_run_id;
    assign o_slice_start     = r_start;
    assign o_end_time        = r_end;
    assign o_first_run       = r_first;
    assign o_response_time   = r_resp;
    assign o_finished        = r_fin;
    assign o_turnaround_time = r_tat;
    assign o_waiting_time    = r_wait;
    assign o_all_done        = r_all_done;

endmodule
